// ===== design/bft_pkg.sv =====
`default_nettype none
package bft_pkg;
    typedef enum logic [2:0] {
        KIND_PIXEL  = 3'd0,
        KIND_CHAR   = 3'd1,
        KIND_CURSOR = 3'd2,
        KIND_FILL   = 3'd3,
        KIND_READ   = 3'd4,
        KIND_GLYPH  = 3'd5,
        KIND_ADV    = 3'd6,
        KIND_NONE   = 3'd7
    } kind_t;

    localparam int unsigned CFG_FONT_WIDTH   = 0;
    localparam int unsigned CFG_FONT_HEIGHT  = 1;
    localparam int unsigned CFG_PROPORTIONAL = 2;

    localparam logic [7:0] FIRST_CODE = 8'd32;
    localparam logic [7:0] LAST_CODE  = 8'd126;
    localparam int unsigned GLYPH_COUNT = 95;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] x_coord;
        logic [7:0] y_coord;
        logic       color;
        logic [7:0] char_code;
        logic [4:0] glyph_row;
        logic [15:0] row_bits;
        logic [4:0] advance_width;
        logic [9:0] frame_address;
    } cmd_t;

    typedef struct packed {
        logic [7:0] echo_char;
        logic [7:0] frame_byte;
        logic       accepted;
    } res_t;

    function automatic logic code_ok(input logic [7:0] code);
        code_ok = (code >= FIRST_CODE) && (code <= LAST_CODE);
    endfunction
endpackage
`default_nettype wire

// ===== design/bft_frame_mem.sv =====
`default_nettype none
module bft_frame_mem #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic [AW-1:0] rd_addr,
    output logic [7:0]         rd_data
);
    logic [7:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

// ===== design/bitmap_font_text_framebuffer_unit.sv =====
`default_nettype none
// one word at a time; each word is decoded, then handled, then its result is offered
// cursor, load, rejected char: result straight after decode; read byte: frame read first; pixel: read-modify-write
// char: glyph row fetched once per row, one read-modify-write per pixel
// fill: one frame byte per cycle; each result is held until m_tready
// after reset a clearing pass zeroes the store; s_tready low meanwhile
// reset is synchronous active low; glyph and advance stores hold no reset value
module bitmap_font_text_framebuffer_unit #(
    parameter int unsigned SCREEN_WIDTH     = 128,
    parameter int unsigned SCREEN_HEIGHT    = 64,
    parameter int unsigned MAX_GLYPH_HEIGHT = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [5:0]  cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // x_coord, y_coord, color, char_code, glyph_row, row_bits, advance_width,
    // frame_address, zero pad
    input  wire logic [63:0] s_tdata,
    // kind
    input  wire logic [2:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // echo_char, frame_byte, accepted, zero pad
    output logic [23:0]      m_tdata
);
    localparam int unsigned PAGES = (SCREEN_HEIGHT + 7) / 8;
    localparam int unsigned FRAME_BYTES = SCREEN_WIDTH * PAGES;
    localparam int unsigned FAW = $clog2(FRAME_BYTES);
    localparam int unsigned GDEPTH = bft_pkg::GLYPH_COUNT * MAX_GLYPH_HEIGHT;
    localparam int unsigned GAW = $clog2(GDEPTH);

    typedef enum logic [9:0] {
        ST_CLEAR  = 10'b0000000001,
        ST_IDLE   = 10'b0000000010,
        ST_DEC    = 10'b0000000100,
        ST_GLYPH  = 10'b0000001000,
        ST_PXRD   = 10'b0000010000,
        ST_PXWAIT = 10'b0000100000,
        ST_PXWR   = 10'b0001000000,
        ST_FILL   = 10'b0010000000,
        ST_RDWAIT = 10'b0100000000,
        ST_OUT    = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    bft_pkg::cmd_t cmd_reg, cmd_next;
    bft_pkg::res_t res_reg, res_next;
    logic [4:0] fw_reg, fw_next;
    logic [5:0] fh_reg, fh_next;
    logic       prop_reg, prop_next;
    logic [7:0] ccol_reg, ccol_next;
    logic [7:0] crow_reg, crow_next;
    logic [FAW:0] cnt_reg, cnt_next;
    logic [3:0] ci_reg, ci_next;
    logic [4:0] ri_reg, ri_next;
    logic        chr_reg, chr_next;
    logic [15:0] bits_reg;

    logic [15:0] glyph_mem [GDEPTH];
    logic [4:0]  adv_mem [bft_pkg::GLYPH_COUNT];
    logic [15:0] glyph_rd;
    logic [4:0]  adv_rd;

    logic             fm_we;
    logic [FAW-1:0]   fm_waddr, fm_raddr;
    logic [7:0]       fm_wdata, fm_rdata;

    bft_frame_mem #(.DEPTH(FRAME_BYTES), .AW(FAW)) u_frame (
        .aclk(aclk), .wr_en(fm_we), .wr_addr(fm_waddr), .wr_data(fm_wdata),
        .rd_addr(fm_raddr), .rd_data(fm_rdata)
    );

    logic [7:0] code_off;
    logic [GAW-1:0] gidx_load, gidx_draw;
    assign code_off = cmd_reg.char_code - bft_pkg::FIRST_CODE;
    assign gidx_load = GAW'(32'(code_off) * MAX_GLYPH_HEIGHT + 32'(cmd_reg.glyph_row));
    assign gidx_draw = GAW'(32'(code_off) * MAX_GLYPH_HEIGHT + 32'(ri_reg));

    logic glyph_we, adv_we;
    always_ff @(posedge aclk) begin
        if (glyph_we) begin
            glyph_mem[gidx_load] <= cmd_reg.row_bits;
        end
        if (adv_we) begin
            adv_mem[code_off[6:0]] <= cmd_reg.advance_width;
        end
        glyph_rd <= glyph_mem[gidx_draw];
        adv_rd   <= adv_mem[code_off[6:0]];
    end

    // shared pixel address unit
    logic [7:0] px_x, px_y;
    logic [8:0] sum_x, sum_y;
    logic       px_in;
    logic [FAW-1:0] px_addr;
    logic [7:0] px_mask;
    logic       px_white;
    assign sum_x = 9'(chr_reg ? ccol_reg : cmd_reg.x_coord) + 9'(chr_reg ? ci_reg : 4'd0);
    assign sum_y = 9'(chr_reg ? crow_reg : cmd_reg.y_coord) + 9'(chr_reg ? ri_reg : 5'd0);
    assign px_x = sum_x[7:0];
    assign px_y = sum_y[7:0];
    assign px_in = (32'(sum_x) < SCREEN_WIDTH) && (32'(sum_y) < SCREEN_HEIGHT);
    assign px_addr = FAW'(32'(px_x) + 32'(px_y[7:3]) * SCREEN_WIDTH);
    assign px_mask = 8'd1 << px_y[2:0];
    assign px_white = chr_reg ? (bits_reg[4'd15 - ci_reg] ? cmd_reg.color : ~cmd_reg.color)
                              : cmd_reg.color;

    logic char_ok;
    assign char_ok = bft_pkg::code_ok(cmd_reg.char_code) && (fw_reg >= 5'd1)
        && (fw_reg <= 5'd16) && (fh_reg >= 6'd1) && (32'(fh_reg) <= MAX_GLYPH_HEIGHT)
        && (32'(ccol_reg) + 32'(fw_reg) <= SCREEN_WIDTH)
        && (32'(crow_reg) + 32'(fh_reg) <= SCREEN_HEIGHT);

    logic [8:0] adv_sum;
    assign adv_sum = 9'(ccol_reg) + 9'(prop_reg ? adv_rd : fw_reg);

    always_comb begin
        state_next = state_reg;
        cmd_next = cmd_reg;
        res_next = res_reg;
        fw_next = fw_reg;
        fh_next = fh_reg;
        prop_next = prop_reg;
        ccol_next = ccol_reg;
        crow_next = crow_reg;
        cnt_next = cnt_reg;
        ci_next = ci_reg;
        ri_next = ri_reg;
        chr_next = chr_reg;
        fm_we = 1'b0;
        fm_waddr = px_addr;
        fm_wdata = px_white ? (fm_rdata | px_mask) : (fm_rdata & ~px_mask);
        fm_raddr = px_addr;
        glyph_we = 1'b0;
        adv_we = 1'b0;
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        if (cfg_we) begin
            unique case (32'(cfg_index))
                bft_pkg::CFG_FONT_WIDTH:   fw_next = cfg_data[4:0];
                bft_pkg::CFG_FONT_HEIGHT:  fh_next = cfg_data;
                bft_pkg::CFG_PROPORTIONAL: prop_next = cfg_data[0];
                default: ;
            endcase
        end
        unique case (state_reg)
            ST_CLEAR, ST_FILL: begin
                fm_we = 1'b1;
                fm_waddr = cnt_reg[FAW-1:0];
                fm_wdata = (state_reg == ST_FILL && cmd_reg.color) ? 8'hFF : 8'h00;
                cnt_next = cnt_reg + 1'b1;
                if (32'(cnt_reg) == FRAME_BYTES - 1) begin
                    state_next = (state_reg == ST_FILL) ? ST_OUT : ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                chr_next = 1'b0;
                if (s_tvalid) begin
                    cmd_next.kind = s_tuser;
                    cmd_next.x_coord = s_tdata[7:0];
                    cmd_next.y_coord = s_tdata[15:8];
                    cmd_next.color = s_tdata[16];
                    cmd_next.char_code = s_tdata[24:17];
                    cmd_next.glyph_row = s_tdata[29:25];
                    cmd_next.row_bits = s_tdata[45:30];
                    cmd_next.advance_width = s_tdata[50:46];
                    cmd_next.frame_address = s_tdata[60:51];
                    state_next = ST_DEC;
                end
            end
            ST_DEC: begin
                res_next = '0;
                chr_next = 1'b0;
                ci_next = '0;
                ri_next = '0;
                cnt_next = '0;
                state_next = ST_OUT;
                fm_raddr = FAW'(cmd_reg.frame_address);
                unique case (bft_pkg::kind_t'(cmd_reg.kind))
                    bft_pkg::KIND_PIXEL: begin
                        if (px_in) begin
                            res_next.accepted = 1'b1;
                            state_next = ST_PXWAIT;
                        end
                    end
                    bft_pkg::KIND_CHAR: begin
                        if (char_ok) begin
                            res_next.accepted = 1'b1;
                            res_next.echo_char = cmd_reg.char_code;
                            chr_next = 1'b1;
                            state_next = ST_GLYPH;
                        end
                    end
                    bft_pkg::KIND_CURSOR: begin
                        ccol_next = cmd_reg.x_coord;
                        crow_next = cmd_reg.y_coord;
                        res_next.accepted = 1'b1;
                    end
                    bft_pkg::KIND_FILL: begin
                        res_next.accepted = 1'b1;
                        state_next = ST_FILL;
                    end
                    bft_pkg::KIND_READ: begin
                        if (32'(cmd_reg.frame_address) < FRAME_BYTES) begin
                            res_next.accepted = 1'b1;
                            state_next = ST_RDWAIT;
                        end
                    end
                    bft_pkg::KIND_GLYPH: begin
                        if (bft_pkg::code_ok(cmd_reg.char_code)
                            && 32'(cmd_reg.glyph_row) < MAX_GLYPH_HEIGHT) begin
                            glyph_we = 1'b1;
                            res_next.accepted = 1'b1;
                        end
                    end
                    bft_pkg::KIND_ADV: begin
                        if (bft_pkg::code_ok(cmd_reg.char_code)) begin
                            adv_we = 1'b1;
                            res_next.accepted = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            ST_GLYPH: begin
                // glyph row address presented here, row data captured in pxrd
                state_next = ST_PXRD;
            end
            ST_PXRD: begin
                state_next = ST_PXWAIT;
            end
            ST_PXWAIT: begin
                state_next = ST_PXWR;
            end
            ST_PXWR: begin
                fm_we = 1'b1;
                state_next = ST_OUT;
                if (chr_reg) begin
                    state_next = ST_PXRD;
                    if (5'(ci_reg) == fw_reg - 5'd1) begin
                        ci_next = '0;
                        if (6'(ri_reg) == fh_reg - 6'd1) begin
                            ccol_next = adv_sum[8] ? 8'hFF : adv_sum[7:0];
                            state_next = ST_OUT;
                        end else begin
                            ri_next = ri_reg + 1'b1;
                            state_next = ST_GLYPH;
                        end
                    end else begin
                        ci_next = ci_reg + 1'b1;
                    end
                end
            end
            ST_RDWAIT: begin
                res_next.frame_byte = fm_rdata;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_PXRD) begin
            bits_reg <= glyph_rd;
        end
        cmd_reg <= cmd_next;
        res_reg <= res_next;
        ci_reg <= ci_next;
        ri_reg <= ri_next;
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            fw_reg <= 5'd7;
            fh_reg <= 6'd10;
            prop_reg <= 1'b0;
            ccol_reg <= '0;
            crow_reg <= '0;
            cnt_reg <= '0;
            chr_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            fw_reg <= fw_next;
            fh_reg <= fh_next;
            prop_reg <= prop_next;
            ccol_reg <= ccol_next;
            crow_reg <= crow_next;
            cnt_reg <= cnt_next;
            chr_reg <= chr_next;
        end
    end

    assign m_tdata = {7'd0, res_reg.accepted, res_reg.frame_byte, res_reg.echo_char};

    a_no_both: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("ready while result pending");
    a_echo_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res_reg.echo_char != 8'd0 |-> res_reg.accepted)
        else $error("echo without accept");
    a_char_ci: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_PXWR && chr_reg |-> 5'(ci_reg) < fw_reg)
        else $error("column beyond cell");
endmodule
`default_nettype wire
